// ===== hw/rtl/h2r_pkg.sv =====
package h2r_pkg;

  // hue offset that lifts any 16-bit hue to a positive multiple-of-turn shift
  localparam int unsigned HueTurn   = 5760;
  localparam int unsigned HueSixth  = 960;
  localparam logic [16:0] HueLift   = 17'(6 * HueTurn);
  localparam logic [8:0]  Q8One     = 9'd256;
  // reciprocals for the two small constant divisions
  localparam logic [12:0] RecipBy15 = 13'd4370;   // ceil(2^16 / 15)
  localparam logic [5:0]  RecipBy6  = 6'd43;      // ceil(2^8 / 6)
  localparam logic [9:0]  SixthW    = 10'(HueSixth);

  // the six 60 degree sectors, named by the two channels that carry c and x
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYA = 3'd2,
    SEC_CYA_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // after hue split and chroma product
  typedef struct packed {
    logic [16:0] vs;      // v*s, Q16
    logic [9:0]  r;       // remainder within the sixth
    logic [6:0]  k;       // index of the sixth on the lifted hue
    logic [3:0]  q6;      // k / 6
    logic [8:0]  v;
  } split_t;

  // channel numerators over 65536*960
  typedef struct packed {
    sector_t     sector;
    logic [25:0] cn;
    logic [25:0] xn;
    logic [25:0] mn;
  } numer_t;

  // clamp a signed q8 value to 0..256
  function automatic logic [8:0] clamp_q8(input logic signed [9:0] x);
    logic [8:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > $signed({1'b0, Q8One})) begin
      res = Q8One;
    end else begin
      res = x[8:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/h2r_if.sv =====
interface hsv_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue;
  logic signed [9:0]  saturation;
  logic signed [9:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== hw/rtl/h2r_split.sv =====
module h2r_split (
  input  logic            clk,
  input  logic            rst,
  hsv_if.sink             hsv_in,
  output logic            out_valid,
  input  logic            out_ready,
  output h2r_pkg::split_t out_data
);
  import h2r_pkg::*;

  // stage 1 registers
  logic        s1_valid;
  logic [16:0] s1_u;
  logic [6:0]  s1_k;
  logic [8:0]  s1_s;
  logic [8:0]  s1_v;
  // stage 2 registers
  logic        s2_valid;
  split_t      s2;

  logic        s1_en;
  logic        s2_en;
  logic [16:0] u_next;
  logic [23:0] k_prod;
  logic [16:0] k960;
  logic [16:0] r_full;
  logic [11:0] q6_prod;

  // stall control, each stage moves when empty or drained
  assign s2_en        = !s2_valid || out_ready;
  assign s1_en        = !s1_valid || s2_en;
  assign hsv_in.ready = s1_en;

  // lift hue positive, sixth index k = floor(u / 960) = floor((u >> 6) / 15)
  assign u_next = 17'(hsv_in.hue) + HueLift;
  assign k_prod = {13'd0, u_next[16:6]} * {11'd0, RecipBy15};

  // remainder within the sixth and k / 6
  assign k960    = {s1_k, 10'd0} - {4'd0, s1_k, 6'd0};
  assign r_full  = s1_u - k960;
  assign q6_prod = {5'd0, s1_k} * {6'd0, RecipBy6};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= hsv_in.valid;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_en && hsv_in.valid) begin
      s1_u <= u_next;
      s1_k <= k_prod[22:16];
      s1_s <= clamp_q8(hsv_in.saturation);
      s1_v <= clamp_q8(hsv_in.brightness);
    end
    if (s2_en && s1_valid) begin
      s2.vs <= {8'd0, s1_v} * {8'd0, s1_s};
      s2.r  <= r_full[9:0];
      s2.k  <= s1_k;
      s2.q6 <= q6_prod[11:8];
      s2.v  <= s1_v;
    end
  end

  assign out_valid = s2_valid;
  assign out_data  = s2;

endmodule

// ===== hw/rtl/h2r_ramp.sv =====
module h2r_ramp (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  h2r_pkg::split_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output h2r_pkg::numer_t out_data
);
  import h2r_pkg::*;

  // stage 3 registers
  logic        s3_valid;
  sector_t     s3_sector;
  logic [16:0] s3_vs;
  logic [9:0]  s3_t;
  logic [25:0] s3_cn;
  logic [25:0] s3_vbase;
  // stage 4 registers
  logic        s4_valid;
  numer_t      s4;

  logic        s3_en;
  logic        s4_en;
  logic [6:0]  sec_diff;
  logic [9:0]  t_next;
  logic [26:0] xn_prod;

  assign s4_en    = !s4_valid || out_ready;
  assign s3_en    = !s3_valid || s4_en;
  assign in_ready = s3_en;

  // sector = k mod 6, ramp falls in odd sixths
  assign sec_diff = in_data.k - {1'b0, in_data.q6, 2'b00} - {2'b00, in_data.q6, 1'b0};
  assign t_next   = in_data.k[0] ? (SixthW - in_data.r) : in_data.r;

  // x numerator, v*s*t
  assign xn_prod = {10'd0, s3_vs} * {17'd0, s3_t};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s3_en) begin
        s3_valid <= in_valid;
      end
      if (s4_en) begin
        s4_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && in_valid) begin
      s3_sector <= sector_t'(sec_diff[2:0]);
      s3_vs     <= in_data.vs;
      s3_t      <= t_next;
      // c = v*s*960 and v*256*960 as shift-add
      s3_cn     <= {in_data.vs[15:0], 10'd0} - {3'd0, in_data.vs, 6'd0};
      s3_vbase  <= {in_data.v[7:0], 18'd0} - {3'd0, in_data.v, 14'd0};
    end
    if (s4_en && s3_valid) begin
      s4.sector <= s3_sector;
      s4.cn     <= s3_cn;
      s4.xn     <= xn_prod[25:0];
      s4.mn     <= s3_vbase - s3_cn;
    end
  end

  assign out_valid = s4_valid;
  assign out_data  = s4;

endmodule

// ===== hw/rtl/h2r_mix.sv =====
module h2r_mix (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  h2r_pkg::numer_t in_data,
  rgb_if.source           rgb_out
);
  import h2r_pkg::*;

  logic        s5_valid;
  logic [7:0]  s5_red;
  logic [7:0]  s5_green;
  logic [7:0]  s5_blue;

  logic        s5_en;
  logic [25:0] r1;
  logic [25:0] g1;
  logic [25:0] b1;
  logic [25:0] r_num;
  logic [25:0] g_num;
  logic [25:0] b_num;
  logic [30:0] r_scl;
  logic [30:0] g_scl;
  logic [30:0] b_scl;

  assign s5_en    = !s5_valid || rgb_out.ready;
  assign in_ready = s5_en;

  // place c and x on the channels by sector
  always_comb begin
    r1 = '0;
    g1 = '0;
    b1 = '0;
    unique case (in_data.sector)
      SEC_RED_YEL: begin r1 = in_data.cn; g1 = in_data.xn; end
      SEC_YEL_GRN: begin r1 = in_data.xn; g1 = in_data.cn; end
      SEC_GRN_CYA: begin g1 = in_data.cn; b1 = in_data.xn; end
      SEC_CYA_BLU: begin g1 = in_data.xn; b1 = in_data.cn; end
      SEC_BLU_MAG: begin r1 = in_data.xn; b1 = in_data.cn; end
      SEC_MAG_RED: begin r1 = in_data.cn; b1 = in_data.xn; end
      default: begin end
    endcase
  end

  // 255 / (65536*960) = 17 / 2^22, so scale by 17 and drop 22 bits
  assign r_num = r1 + in_data.mn;
  assign g_num = g1 + in_data.mn;
  assign b_num = b1 + in_data.mn;
  assign r_scl = {1'b0, r_num, 4'd0} + {5'd0, r_num};
  assign g_scl = {1'b0, g_num, 4'd0} + {5'd0, g_num};
  assign b_scl = {1'b0, b_num, 4'd0} + {5'd0, b_num};

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_en) begin
      s5_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_en && in_valid) begin
      s5_red   <= r_scl[29:22];
      s5_green <= g_scl[29:22];
      s5_blue  <= b_scl[29:22];
    end
  end

  assign rgb_out.valid = s5_valid;
  assign rgb_out.red   = s5_red;
  assign rgb_out.green = s5_green;
  assign rgb_out.blue  = s5_blue;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// HSV to RGB colour converter, one pixel per beat.
// hsv_in carries hue (signed, 1/16 degree, wrapped into one turn), saturation
// and brightness (signed Q8, clamped to 0..256). rgb_out carries 8-bit red,
// green and blue, each floor(255 * (channel + m)), computed exactly.
// Both channels use valid/ready; a beat moves when both are high.
// One register stage each lies between an accepted input beat and the result
// on rgb_out, in order: hue split, remainder and chroma, sector and ramp,
// ramp product, and channel mix into the output register.
// Throughput: one pixel per cycle, limited by nothing but the handshake.
// Each stage holds its own valid bit and advances when empty or when the
// stage after it moves, so a stalled receiver fills bubbles first and only
// then backs up to hsv_in.ready; no beat is dropped or repeated.
// Reset (rst, synchronous) empties all stages; there is no other state.
module hsv_to_rgb_converter_top (
  input  logic  clk,
  input  logic  rst,
  hsv_if.sink   hsv_in,
  rgb_if.source rgb_out
);
  import h2r_pkg::*;

  logic   split_valid;
  logic   split_ready;
  split_t split_data;
  logic   numer_valid;
  logic   numer_ready;
  numer_t numer_data;

  // hue split, clamp and chroma product
  h2r_split u_split (
    .clk       (clk),
    .rst       (rst),
    .hsv_in    (hsv_in),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  // sector, ramp and channel numerators
  h2r_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (numer_valid),
    .out_ready (numer_ready),
    .out_data  (numer_data)
  );

  // channel placement and scaling to 8 bits
  h2r_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (numer_valid),
    .in_ready (numer_ready),
    .in_data  (numer_data),
    .rgb_out  (rgb_out)
  );

endmodule
